FILE: rtl/fmosc_pkg.sv
package fmosc_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FM_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_INDEX  = 3'd4;

    // Waveform codes.
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SAWTOOTH = 2'd2;
    localparam logic [1:0] WAVE_SQUARE   = 2'd3;

    // Modulation mode codes; the spare code behaves as carrier.
    localparam logic [1:0] FM_CARRIER = 2'd0;
    localparam logic [1:0] FM_LINEAR  = 2'd1;
    localparam logic [1:0] FM_EXP     = 2'd2;

    // Reset values of the registers.
    localparam logic [31:0]        PHASE_STEP_RESET = 32'd42852281;
    localparam logic [15:0]        AMPLITUDE_RESET  = 16'd32768;
    localparam logic signed [15:0] MOD_INDEX_RESET  = 16'sd256;

    // Arithmetic constants.
    localparam logic [63:0]        Q30_ONE        = 64'd1073741824;
    localparam logic [63:0]        HALF_PI_Q30    = 64'd1686629713;
    localparam logic [63:0]        LN2_Q30        = 64'd744261118;
    localparam logic [29:0]        INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic signed [31:0] EXP_LIMIT      = 32'sd83886080;
    localparam logic [31:0]        HALF_TURN      = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_PREP,
        ST_TBL,
        ST_EMUL,
        ST_UPD,
        ST_LOOK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic mult;
        logic prep;
        logic tbl;
        logic emul;
        logic upd;
        logic look;
        logic outp;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/fmosc_ctrl.sv
module fmosc_ctrl
    import fmosc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_dp_status i_status,
    output logic       o_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_MULT;
                end
            end
            ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_TBL;
            end
            ST_TBL: begin
                o_cmd.tbl = 1'b1;
                n_state   = ST_EMUL;
            end
            ST_EMUL: begin
                o_cmd.emul = 1'b1;
                n_state    = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_LOOK;
            end
            ST_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                // The result register must be free before the item is finished.
                if (i_status.out_free) begin
                    o_cmd.outp = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/fmosc_dp.sv
module fmosc_dp
    import fmosc_pkg::*;
#(
    parameter int CHANNELS         = 32,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int EXP_TABLE_DEPTH  = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [4:0]           i_channel,
    input  logic signed [15:0]   i_modulator,
    input  logic                 i_frame_end,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic signed [15:0]   o_sample,
    output logic [4:0]           o_out_channel
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SA_W = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
    localparam int SD_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int EA_W = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
    localparam int ED_W = $clog2(EXP_TABLE_DEPTH + 1);

    typedef logic signed [16:0] t_sine_rom [SINE_TABLE_DEPTH];
    typedef logic [31:0]        t_exp_rom  [EXP_TABLE_DEPTH];

    // Sine of each table point, Taylor series in Q30, rounded to Q1.15.
    function automatic t_sine_rom build_sine();
        t_sine_rom   tbl;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            p = (64'(k) << 32) / SINE_TABLE_DEPTH;
            q = p >> 30;
            r = p & 64'h3FFF_FFFF;
            if (q[0]) begin
                r = Q30_ONE - r;
            end
            x    = (r * HALF_PI_Q30) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int j = 1; j <= 10; j++) begin
                term = ((term * x2) >> 30) / 64'((2 * j) * (2 * j + 1));
                if (j % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum + 16384) >>> 15;
            if (v > 32768) begin
                v = 32768;
            end
            tbl[k] = (q >= 2) ? 17'(-v) : 17'(v);
        end
        return tbl;
    endfunction

    // Fractional powers of two in Q30.
    function automatic t_exp_rom build_exp();
        t_exp_rom    tbl;
        logic [63:0] f;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            f    = (64'(k) << 30) / EXP_TABLE_DEPTH;
            y    = (f * LN2_Q30) >> 30;
            term = Q30_ONE;
            sum  = Q30_ONE;
            for (int j = 1; j <= 12; j++) begin
                term = ((term * y) >> 30) / 64'(j);
                sum  = sum + term;
            end
            tbl[k] = 32'(sum);
        end
        return tbl;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine();
    localparam t_exp_rom  EXP_ROM  = build_exp();

    // Configuration registers.
    logic [1:0]         r_waveform;
    logic [1:0]         r_fm_mode;
    logic [31:0]        r_phase_step;
    logic [15:0]        r_amplitude;
    logic signed [15:0] r_mod_index;

    // Phase state.
    logic [31:0] r_shared_phase;
    logic [31:0] r_ch_phase [CHANNELS];

    // Item and working registers.
    logic [4:0]          r_ch;
    logic signed [15:0]  r_mod;
    logic                r_frame_end;
    logic signed [31:0]  r_prod;
    logic [EA_W-1:0]     r_k;
    logic [5:0]          r_sh;
    logic [60:0]         r_lin;
    logic                r_neg;
    logic [31:0]         r_base;
    logic [31:0]         r_tbl;
    logic [31:0]         r_phase;
    logic [63:0]         r_scaled;
    logic [SA_W-1:0]     r_sidx;
    logic signed [16:0]  r_wave;
    logic signed [16:0]  r_sval;
    logic                r_valid;
    logic signed [15:0]  r_sample;
    logic [4:0]          r_out_ch;

    logic                ch_ok;
    logic [CH_W-1:0]     ch_idx;
    logic signed [31:0]  x_cl;
    logic [27:0]         ux;
    logic [22+ED_W:0]    k_prod;
    logic [30:0]         mag;
    logic [31:0]         off;
    logic [31:0]         inc;
    logic [31+SD_W:0]    s_prod;
    logic [31:0]         tri_d;
    logic signed [17:0]  tri_w;
    logic signed [16:0]  wave_n;
    logic signed [16:0]  w_sel;
    logic signed [34:0]  y_full;
    logic signed [19:0]  y_sh;
    logic signed [15:0]  y_sat;

    assign ch_ok  = {1'b0, r_ch} < 6'(CHANNELS);
    assign ch_idx = r_ch[CH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform   <= WAVE_SINE;
            r_fm_mode    <= FM_CARRIER;
            r_phase_step <= PHASE_STEP_RESET;
            r_amplitude  <= AMPLITUDE_RESET;
            r_mod_index  <= MOD_INDEX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAVEFORM:   r_waveform   <= i_cfg_data[1:0];
                CFG_FM_MODE:    r_fm_mode    <= i_cfg_data[1:0];
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                CFG_AMPLITUDE:  r_amplitude  <= i_cfg_data[15:0];
                CFG_MOD_INDEX:  r_mod_index  <= $signed(i_cfg_data[15:0]);
                default: begin
                end
            endcase
        end
    end

    // Exponential step: clamp, split into octave and fraction, index the table; also the linear offset and sine index.
    always_comb begin
        x_cl = r_prod;
        if (r_prod > EXP_LIMIT) begin
            x_cl = EXP_LIMIT;
        end else if (r_prod < -EXP_LIMIT) begin
            x_cl = -EXP_LIMIT;
        end
        ux     = 28'(x_cl + EXP_LIMIT);
        k_prod = (23 + ED_W)'(ux[22:0]) * (23 + ED_W)'(EXP_TABLE_DEPTH);
        mag    = r_prod[31] ? 31'(-r_prod) : 31'(r_prod);
        off    = r_lin[54:23];
        inc    = 32'(r_scaled >> r_sh);
        s_prod = (32 + SD_W)'(r_phase) * (32 + SD_W)'(SINE_TABLE_DEPTH);
    end

    // Non-table waveforms.
    always_comb begin
        tri_d = r_phase[31] ? (r_phase - HALF_TURN) : (HALF_TURN - r_phase);
        tri_w = $signed({1'b0, tri_d[31:15]}) - 18'sd32768;
        case (r_waveform)
            WAVE_TRIANGLE: wave_n = 17'(tri_w);
            WAVE_SAWTOOTH: wave_n = $signed({1'b0, r_phase[31:16]}) - 17'sd32768;
            WAVE_SQUARE:   wave_n = r_phase[31] ? -17'sd32768 : 17'sd32768;
            default:       wave_n = 17'sd0;
        endcase
    end

    // Gain, round half up, saturate.
    always_comb begin
        w_sel  = (r_waveform == WAVE_SINE) ? r_sval : r_wave;
        y_full = 35'(w_sel) * 35'($signed({1'b0, r_amplitude})) + 35'sd16384;
        y_sh   = 20'(y_full >>> 15);
        if (y_sh > 20'sd32767) begin
            y_sat = 16'sd32767;
        end else if (y_sh < -20'sd32768) begin
            y_sat = -16'sd32768;
        end else begin
            y_sat = 16'(y_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch        <= i_channel;
            r_mod       <= i_modulator;
            r_frame_end <= i_frame_end;
        end
        if (i_cmd.mult) begin
            r_prod <= r_mod_index * r_mod;
        end
        if (i_cmd.prep) begin
            r_k   <= k_prod[23 +: EA_W];
            r_sh  <= 6'd40 - {1'b0, ux[27:23]};
            r_lin <= 61'(mag) * 61'(INV_TWO_PI_Q32);
            r_neg <= r_prod[31];
            if (r_fm_mode == FM_EXP) begin
                r_base <= ch_ok ? r_ch_phase[ch_idx] : 32'd0;
            end else begin
                r_base <= r_shared_phase;
            end
        end
        if (i_cmd.tbl) begin
            r_tbl <= EXP_ROM[r_k];
            if (r_fm_mode == FM_LINEAR) begin
                r_phase <= r_base + (r_neg ? (32'd0 - off) : off);
            end else begin
                r_phase <= r_base;
            end
        end
        if (i_cmd.emul) begin
            r_scaled <= 64'(r_phase_step) * 64'(r_tbl);
        end
        if (i_cmd.upd) begin
            r_sidx <= s_prod[32 +: SA_W];
            r_wave <= wave_n;
        end
        if (i_cmd.look) begin
            r_sval <= SINE_ROM[r_sidx];
        end
        if (i_cmd.outp) begin
            r_sample <= y_sat;
            r_out_ch <= r_ch;
        end
    end

    // Phase state is architectural and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shared_phase <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_ch_phase[i] <= '0;
            end
        end else if (i_cmd.upd) begin
            if (r_fm_mode == FM_EXP) begin
                if (ch_ok) begin
                    r_ch_phase[ch_idx] <= r_phase + inc;
                end
            end else if (r_frame_end) begin
                r_shared_phase <= r_shared_phase + r_phase_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.outp) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_valid || !i_stall;
    assign o_valid           = r_valid;
    assign o_sample          = r_sample;
    assign o_out_channel     = r_out_ch;

endmodule

FILE: rtl/fm_waveform_oscillator.sv
// Phase-accumulator oscillator with frequency modulation. Each accepted item
// (a channel number, a Q1.15 modulator sample and a frame-end flag) yields one
// Q1.15 sample of sine, triangle, sawtooth or square wave, scaled by the
// amplitude register and saturated. In carrier mode the shared phase drives the
// wave, in linear mode index*modulator/(2*pi) turns are added to it, and in both
// the shared phase advances by the step after an item marked frame end. In
// exponential mode every channel keeps its own phase, advanced by
// step*2^clamp(index*modulator, -10, +10) octaves. An item passes through the
// seven-step sequence of the controller, the shared multiplier stages and the
// registered sine table read before the next item is accepted; a result that is
// not taken holds the block in its last step. The user writes configuration
// via its own port only while the block is idle; the block does not check it.
module fm_waveform_oscillator
    import fmosc_pkg::*;
#(
    parameter int CHANNELS         = 32,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int EXP_TABLE_DEPTH  = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input item channel.
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [4:0]           i_channel,
    input  logic signed [15:0]   i_modulator,
    input  logic                 i_frame_end,
    // Result item channel.
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [15:0]   o_sample,
    output logic [4:0]           o_out_channel,
    // Configuration write port; it is always ready.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    // The controller steps each item through the datapath.
    fmosc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // The datapath holds the registers, phase state, tables and result register.
    fmosc_dp #(
        .CHANNELS         (CHANNELS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .EXP_TABLE_DEPTH  (EXP_TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_channel     (i_channel),
        .i_modulator   (i_modulator),
        .i_frame_end   (i_frame_end),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_sample      (o_sample),
        .o_out_channel (o_out_channel)
    );

endmodule

FILE: tb/sv/fm_osc_checker.sv
module fm_osc_checker
    import fmosc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  logic [4:0]           i_channel,
    input  logic signed [15:0]   i_modulator,
    input  logic                 i_frame_end,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  logic signed [15:0]   o_sample,
    input  logic [4:0]           o_out_channel,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH    = 32;
    localparam int SINE_SIZE = 1024;
    localparam int EXP_SIZE  = 256;

    typedef struct {
        logic signed [15:0] sample;
        logic [4:0]         chan;
    } t_osc_sample;

    int          sine_q15 [SINE_SIZE];
    bit [31:0]   exp2_q30 [EXP_SIZE];

    logic [1:0]         wave_sel;
    logic [1:0]         mode_sel;
    logic [31:0]        step_r;
    logic [15:0]        gain_r;
    logic signed [15:0] index_r;
    logic [31:0]        shared_ph;
    logic [31:0]        chan_ph [NUM_CH];

    t_osc_sample samples_due[$];

    // Sine of a phase, a Taylor series in Q30 rounded to Q1.15.
    function automatic int sine_at(input logic [31:0] ph);
        longint unsigned r, x, x2, term;
        longint          acc;
        int              v;
        r = ph[29:0];
        if (ph[30]) r = 64'd1073741824 - r;
        x    = (r * 64'd1686629713) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int j = 1; j <= 10; j++) begin
            term = ((term * x2) >> 30) / longint'((2 * j) * (2 * j + 1));
            if (j % 2 == 1) acc -= term;
            else acc += term;
        end
        if (acc < 0) acc = 0;
        v = int'((longint'(acc) + 16384) >>> 15);
        if (v > 32768) v = 32768;
        return ph[31] ? -v : v;
    endfunction

    function automatic logic [31:0] exp2_at(input int k);
        longint unsigned f, y, term, acc;
        f    = (longint'(k) << 30) / EXP_SIZE;
        y    = (f * 64'd744261118) >> 30;
        term = 64'd1073741824;
        acc  = term;
        for (int j = 1; j <= 12; j++) begin
            term = ((term * y) >> 30) / longint'(j);
            acc += term;
        end
        return acc[31:0];
    endfunction

    function automatic int wave_value(input logic [31:0] ph);
        longint d;
        case (wave_sel)
            WAVE_SINE:     return sine_q15[ph[31:22]];
            WAVE_TRIANGLE: begin
                d = longint'(ph) - 64'sd2147483648;
                if (d < 0) d = -d;
                return int'(d >>> 15) - 32768;
            end
            WAVE_SAWTOOTH: return int'(ph[31:16]) - 32768;
            default:       return ph[31] ? -32768 : 32768;
        endcase
    endfunction

    function automatic logic [31:0] exp_advance(input int prod);
        int              x, n;
        logic [31:0]     ux;
        longint unsigned scaled;
        x = prod;
        if (x > 83886080) x = 83886080;
        if (x < -83886080) x = -83886080;
        ux     = x + 83886080;
        n      = int'(ux >> 23) - 10;
        scaled = longint'(step_r) * longint'(exp2_q30[ux[22:15]]);
        scaled = scaled >> (30 - n);
        return scaled[31:0];
    endfunction

    // Works out the sample for one item and moves the phase state on.
    function automatic t_osc_sample oscillate(input logic [4:0] ch,
                                              input logic signed [15:0] md,
                                              input logic fe);
        t_osc_sample     res;
        int              prod;
        logic [31:0]     ph, off;
        longint unsigned mag;
        longint          y;
        prod = int'(index_r) * int'(md);
        if (mode_sel == FM_EXP) begin
            ph          = chan_ph[ch];
            chan_ph[ch] = ph + exp_advance(prod);
        end else begin
            ph = shared_ph;
            if (mode_sel == FM_LINEAR) begin
                mag = (prod < 0) ? longint'(-longint'(prod)) : longint'(prod);
                mag = (mag * 64'd683565276) >> 23;
                off = mag[31:0];
                if (prod < 0) off = -off;
                ph += off;
            end
            if (fe) shared_ph += step_r;
        end
        y = (longint'(wave_value(ph)) * longint'(gain_r) + 16384) >>> 15;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        res.sample = y[15:0];
        res.chan   = ch;
        return res;
    endfunction

    initial begin
        for (int k = 0; k < SINE_SIZE; k++)
            sine_q15[k] = sine_at(32'(k) << 22);
        for (int k = 0; k < EXP_SIZE; k++)
            exp2_q30[k] = exp2_at(k);
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_osc_sample want;
        if (!i_rst_n) begin
            wave_sel  = WAVE_SINE;
            mode_sel  = FM_CARRIER;
            step_r    = PHASE_STEP_RESET;
            gain_r    = AMPLITUDE_RESET;
            index_r   = MOD_INDEX_RESET;
            shared_ph = '0;
            for (int c = 0; c < NUM_CH; c++) chan_ph[c] = '0;
            samples_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WAVEFORM:   wave_sel = i_cfg_data[1:0];
                    CFG_FM_MODE:    mode_sel = i_cfg_data[1:0];
                    CFG_PHASE_STEP: step_r   = i_cfg_data;
                    CFG_AMPLITUDE:  gain_r   = i_cfg_data[15:0];
                    CFG_MOD_INDEX:  index_r  = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                if (samples_due.size() == 0) begin
                    $error("unexpected sample %0d on channel %0d", o_sample, o_out_channel);
                    o_errors++;
                end else begin
                    want = samples_due.pop_front();
                    if (o_sample !== want.sample) begin
                        $error("sample: expected %0d, got %0d", want.sample, o_sample);
                        o_errors++;
                    end
                    if (o_out_channel !== want.chan) begin
                        $error("out_channel: expected %0d, got %0d", want.chan,
                               o_out_channel);
                        o_errors++;
                    end
                end
            end
            if (i_valid && !o_stall)
                samples_due.push_back(oscillate(i_channel, i_modulator, i_frame_end));
        end
        o_pending <= samples_due.size();
    end

endmodule

FILE: tb/sv/tb.sv
module tb;
    import fmosc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [4:0]           i_channel;
    logic signed [15:0]   i_modulator;
    logic                 i_frame_end;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [15:0]   o_sample;
    logic [4:0]           o_out_channel;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;
    int                   fail_count;
    int                   samples_pending;

    // Flags that steer the receiver: a quiet stretch with no stalls at all, and a
    // request for one long hold-off that the receiver counts out by itself.
    bit quiet_run;
    bit hold_off_req;
    int hold_off_left;

    fm_waveform_oscillator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_channel     (i_channel),
        .i_modulator   (i_modulator),
        .i_frame_end   (i_frame_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample      (o_sample),
        .o_out_channel (o_out_channel),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    fm_osc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_channel     (i_channel),
        .i_modulator   (i_modulator),
        .i_frame_end   (i_frame_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample      (o_sample),
        .o_out_channel (o_out_channel),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (fail_count),
        .o_pending     (samples_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls in about one cycle in seven, except during the quiet
    // stretch. A hold-off keeps the stall high until the receiver has counted it out,
    // so that the block fills up and pushes back on the sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left--;
            i_stall <= 1'b1;
        end else if (hold_off_req) begin
            hold_off_req  = 1'b0;
            hold_off_left = 200;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet_run && ($urandom_range(99) < 14);
        end
    end

    // Writes one register. The port is written only while the block is idle, and
    // the valid is lowered for one cycle afterwards before any further write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one item and returns at the edge that accepts it. The valid is left
    // high so that back-to-back items need no second assignment in a step.
    task automatic send_item(input logic [4:0] ch, input logic signed [15:0] md,
                             input logic fe);
        if (!quiet_run && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_channel   <= ch;
        i_modulator <= md;
        i_frame_end <= fe;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Lowers the valid and waits until every expected sample has come back,
    // then lets the block's full latency pass before anything else happens.
    task automatic drain;
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (samples_pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_all(input logic [1:0] wv, input logic [1:0] md,
                           input logic [31:0] st, input logic [15:0] amp,
                           input logic [15:0] idx);
        write_reg(CFG_WAVEFORM, 32'(wv));
        write_reg(CFG_FM_MODE, 32'(md));
        write_reg(CFG_PHASE_STEP, st);
        write_reg(CFG_AMPLITUDE, 32'(amp));
        write_reg(CFG_MOD_INDEX, 32'(idx));
    endtask

    function automatic logic [15:0] pick_mod();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [31:0] step_pick;
        logic [15:0] gain_pick, index_pick;
        logic [1:0]  mode_pick;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_channel     = '0;
        i_modulator   = '0;
        i_frame_end   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_WAVEFORM;
        i_cfg_data    = '0;
        quiet_run     = 1'b0;
        hold_off_req  = 1'b0;
        hold_off_left = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings first: carrier sine with the shared phase advancing only
        // on items that end a frame, with field extremes on either side.
        send_item(5'd0, 16'sh0000, 1'b0);
        send_item(5'd31, 16'sh7FFF, 1'b1);
        send_item(5'd0, 16'sh8000, 1'b1);
        drain();

        // Linear modulation through every waveform with full-scale modulators.
        for (int w = 0; w < 4; w++) begin
            set_all(2'(w), FM_LINEAR, 32'h1234_5678, 16'd32768, 16'h7FFF);
            send_item(5'd3, 16'sh7FFF, 1'b1);
            send_item(5'd4, 16'sh8000, 1'b0);
            drain();
        end

        // Exponential mode, with the octave product clamped in both directions and
        // the largest step, plus a gain above one so the output saturates.
        set_all(WAVE_TRIANGLE, FM_EXP, 32'hFFFF_FFFF, 16'hFFFF, 16'h7FFF);
        send_item(5'd31, 16'sh7FFF, 1'b1);
        send_item(5'd31, 16'sh8000, 1'b0);
        send_item(5'd31, 16'sh0000, 1'b0);
        drain();
        set_all(WAVE_SQUARE, FM_EXP, 32'd0, 16'd0, 16'h8000);
        send_item(5'd1, 16'sh7FFF, 1'b0);
        send_item(5'd1, 16'sh8000, 1'b1);
        drain();

        // The spare mode code runs as a carrier.
        set_all(WAVE_SAWTOOTH, 2'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
        send_item(5'd7, 16'sh4000, 1'b1);
        send_item(5'd8, 16'sh4000, 1'b1);
        drain();

        // Random phases. Every phase rewrites all registers, leaning on the
        // modulated modes and on the extremes of each register.
        for (int ph = 0; ph < 11; ph++) begin
            mode_pick = ($urandom_range(9) < 8) ? 2'($urandom_range(1, 2))
                                                : 2'($urandom_range(0, 3));
            case ($urandom_range(5))
                0:       step_pick = 32'd0;
                1:       step_pick = 32'hFFFF_FFFF;
                2:       step_pick = 32'($urandom_range(1, 32'h00FF_FFFF));
                default: step_pick = $urandom;
            endcase
            case ($urandom_range(5))
                0:       gain_pick = 16'd0;
                1:       gain_pick = 16'd32768;
                2:       gain_pick = 16'hFFFF;
                default: gain_pick = 16'($urandom_range(0, 32768));
            endcase
            case ($urandom_range(5))
                0:       index_pick = 16'h7FFF;
                1:       index_pick = 16'h8000;
                2:       index_pick = 16'($urandom_range(0, 1023)) - 16'd512;
                default: index_pick = 16'($urandom);
            endcase
            set_all(2'($urandom_range(3)), mode_pick, step_pick, gain_pick, index_pick);
            quiet_run = (ph == 7);
            for (int n = 0; n < 50; n++) begin
                if (ph == 3 && n == 10) hold_off_req = 1'b1;
                if (ph == 5 && n == 25) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (samples_pending != 0) @(posedge i_clk);
                end
                send_item(5'($urandom), pick_mod(), 1'($urandom_range(3) == 0));
            end
            drain();
        end
        quiet_run = 1'b0;

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/fmosc_pkg.sv
rtl/fmosc_ctrl.sv
rtl/fmosc_dp.sv
rtl/fm_waveform_oscillator.sv
tb/sv/fm_osc_checker.sv
tb/sv/tb.sv
